// ----- rtl/spinor_pkg.sv -----
// spinor_pkg: command codes and fixed reply bytes of the spi nor flash device
// no dependencies; used by spi_nor_flash_device
`default_nettype none

package spinor_pkg;

  localparam logic [7:0] OpJedecId = 8'h9F;
  localparam logic [7:0] OpStatus  = 8'h05;
  localparam logic [7:0] OpWren    = 8'h06;
  localparam logic [7:0] OpRead    = 8'h03;
  localparam logic [7:0] OpProgram = 8'h02;
  localparam logic [7:0] OpErase   = 8'h60;

  localparam logic [7:0] IdByte0   = 8'hEF;
  localparam logic [7:0] IdByte1   = 8'h40;
  localparam logic [7:0] IdByte2   = 8'h14;
  localparam logic [7:0] IdleByte  = 8'hFF;

  localparam int unsigned PosW   = 3;
  localparam logic [PosW-1:0] PosMax = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/spi_nor_flash_device.sv -----
// spi_nor_flash_device: byte-slot model of a small spi nor flash slave
// depends on spinor_pkg (command codes, reply bytes)
//
// channel  direction  handshake                 payload
// in       slave      in_valid_i / in_ready_o   start_of_transfer_i, tx_byte_i
// out      master     out_valid_o / out_ready_i rx_byte_o
//
// one transaction in gives one transaction out; a byte can be taken every cycle while not stalled,
// its reply appears in the next cycle from the output register and memory read port
// a program data byte writes the array in the cycle after it is taken (read, and, write)
// reset marks every array byte as erased through per-byte valid flags, no clear sweep
// the input stalls only while a reply waits and out_ready_i is low
`default_nettype none

module spi_nor_flash_device #(
  parameter int unsigned MEMORY_BYTES = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       start_of_transfer_i,
  input  wire logic [7:0] tx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] rx_byte_o
);

  localparam int unsigned AddrW = (MEMORY_BYTES > 1) ? $clog2(MEMORY_BYTES) : 1;
  localparam logic [AddrW-1:0] AddrLast = AddrW'(MEMORY_BYTES - 1);

  // state
  logic [7:0]                  cmd_q, cmd_d;
  logic [spinor_pkg::PosW-1:0] pos_q, pos_d;
  logic [AddrW-1:0]            addr_q, addr_d;
  logic                        wel_q, wel_d;
  logic                        granted_q, granted_d;

  // output stage
  logic                        out_valid_q;
  logic                        sel_mem_q, sel_mem_d;
  logic [7:0]                  rx_const_q, rx_const_d;
  logic [7:0]                  rd_q;
  logic                        rd_vld_q;

  // deferred program write
  logic                        wr_pend_q, wr_pend_d;
  logic [AddrW-1:0]            wr_addr_q;
  logic [7:0]                  wr_data_q;

  logic [7:0]                  mem_q [MEMORY_BYTES];
  logic [MEMORY_BYTES-1:0]     vld_q;
  logic                        erase;
  logic                        accept;
  logic [AddrW-1:0]            wrap_lut [256];
  logic [AddrW-1:0]            addr_inc;

  // tx byte modulo memory size, constant table
  for (genvar g = 0; g < 256; g++) begin : g_wrap
    assign wrap_lut[g] = AddrW'(g % MEMORY_BYTES);
  end

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign rx_byte_o   = sel_mem_q ? (rd_vld_q ? rd_q : spinor_pkg::IdleByte) : rx_const_q;
  assign addr_inc    = (addr_q == AddrLast) ? '0 : addr_q + AddrW'(1);

  always_comb begin
    cmd_d      = cmd_q;
    pos_d      = pos_q;
    addr_d     = addr_q;
    wel_d      = wel_q;
    granted_d  = granted_q;
    sel_mem_d  = 1'b0;
    rx_const_d = spinor_pkg::IdleByte;
    wr_pend_d  = 1'b0;
    erase      = 1'b0;
    if (start_of_transfer_i) begin
      cmd_d     = tx_byte_i;
      pos_d     = '0;
      granted_d = 1'b0;
      if (tx_byte_i == spinor_pkg::OpWren) begin
        wel_d = 1'b1;
      end else if (tx_byte_i == spinor_pkg::OpErase && wel_q) begin
        erase = 1'b1;
        wel_d = 1'b0;
      end
    end else begin
      if (pos_q < spinor_pkg::PosMax) begin
        pos_d = pos_q + spinor_pkg::PosW'(1);
      end
      case (cmd_q)
        spinor_pkg::OpJedecId: begin
          if (pos_d == spinor_pkg::PosW'(1)) begin
            rx_const_d = spinor_pkg::IdByte0;
          end else if (pos_d == spinor_pkg::PosW'(2)) begin
            rx_const_d = spinor_pkg::IdByte1;
          end else if (pos_d == spinor_pkg::PosW'(3)) begin
            rx_const_d = spinor_pkg::IdByte2;
          end
        end
        spinor_pkg::OpStatus: begin
          if (pos_d == spinor_pkg::PosW'(1)) begin
            rx_const_d = {6'b0, wel_q, 1'b0};
          end
        end
        spinor_pkg::OpRead: begin
          if (pos_d == spinor_pkg::PosW'(1)) begin
            addr_d = wrap_lut[tx_byte_i];
          end else begin
            sel_mem_d = 1'b1;
            addr_d    = addr_inc;
          end
        end
        spinor_pkg::OpProgram: begin
          if (pos_d == spinor_pkg::PosW'(1)) begin
            if (wel_q) begin
              granted_d = 1'b1;
              wel_d     = 1'b0;
              addr_d    = wrap_lut[tx_byte_i];
            end
          end else if (granted_q) begin
            wr_pend_d = 1'b1;
            addr_d    = addr_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '0;
      pos_q       <= '0;
      addr_q      <= '0;
      wel_q       <= 1'b0;
      granted_q   <= 1'b0;
      out_valid_q <= 1'b0;
      sel_mem_q   <= 1'b0;
      wr_pend_q   <= 1'b0;
    end else begin
      wr_pend_q <= accept && wr_pend_d;
      if (accept) begin
        cmd_q       <= cmd_d;
        pos_q       <= pos_d;
        addr_q      <= addr_d;
        wel_q       <= wel_d;
        granted_q   <= granted_d;
        sel_mem_q   <= sel_mem_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rx_const_q <= rx_const_d;
      wr_addr_q  <= addr_q;
      wr_data_q  <= tx_byte_i;
    end
  end

  // per-byte written flags; an erase wins over a program write in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        rd_vld_q <= vld_q[addr_q];
      end
      if (accept && erase) begin
        vld_q <= '0;
      end else if (wr_pend_q) begin
        vld_q[wr_addr_q] <= 1'b1;
      end
    end
  end

  // array: one write port, one registered read port at the running address
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      mem_q[wr_addr_q] <= (rd_vld_q ? rd_q : spinor_pkg::IdleByte) & wr_data_q;
    end
    if (accept) begin
      rd_q <= mem_q[addr_q];
    end
  end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// testbench for spi_nor_flash_device: byte-slot traffic with random idling on both channels
// replies are predicted from a behavioral copy of the flash and compared in order
// depends on rtl/spinor_pkg.sv and rtl/spi_nor_flash_device.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned MemBytes      = 256;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned TailCycles    = 10;

  logic       clk_i               = 1'b0;
  logic       rst_ni              = 1'b0;
  logic       in_valid_i          = 1'b0;
  logic       start_of_transfer_i = 1'b0;
  logic [7:0] tx_byte_i           = 8'h00;
  logic       out_ready_i         = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] rx_byte_o;

  spi_nor_flash_device #(
    .MEMORY_BYTES(MemBytes)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .start_of_transfer_i(start_of_transfer_i),
    .tx_byte_i          (tx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .rx_byte_o          (rx_byte_o)
  );

  always #5 clk_i = ~clk_i;

  // behavioral copy of the flash
  logic [7:0]                  flash_mem [MemBytes];
  logic                        wel;
  logic                        prog_ok;
  logic [7:0]                  cur_op;
  logic [7:0]                  next_addr;
  logic [spinor_pkg::PosW-1:0] slot_pos;

  logic [7:0]  expected_rx [$];
  int unsigned error_count = 0;
  int unsigned sent_items  = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_hold  = 0;
  logic        calm        = 1'b0;

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [7:0] flash_reply(input logic sot, input logic [7:0] b);
    logic [7:0] reply;
    reply = spinor_pkg::IdleByte;
    if (sot) begin
      cur_op   = b;
      slot_pos = '0;
      prog_ok  = 1'b0;
      if (b == spinor_pkg::OpWren) begin
        wel = 1'b1;
      end else if (b == spinor_pkg::OpErase && wel) begin
        for (int i = 0; i < MemBytes; i++) flash_mem[i] = spinor_pkg::IdleByte;
        wel = 1'b0;
      end
    end else begin
      if (slot_pos < spinor_pkg::PosMax) slot_pos = slot_pos + spinor_pkg::PosW'(1);
      case (cur_op)
        spinor_pkg::OpJedecId: begin
          if (slot_pos == spinor_pkg::PosW'(1)) reply = spinor_pkg::IdByte0;
          else if (slot_pos == spinor_pkg::PosW'(2)) reply = spinor_pkg::IdByte1;
          else if (slot_pos == spinor_pkg::PosW'(3)) reply = spinor_pkg::IdByte2;
        end
        spinor_pkg::OpStatus: begin
          if (slot_pos == spinor_pkg::PosW'(1)) reply = {6'b0, wel, 1'b0};
        end
        spinor_pkg::OpRead: begin
          if (slot_pos == spinor_pkg::PosW'(1)) begin
            next_addr = 8'(int'(b) % MemBytes);
          end else begin
            reply     = flash_mem[next_addr];
            next_addr = 8'((int'(next_addr) + 1) % MemBytes);
          end
        end
        spinor_pkg::OpProgram: begin
          if (slot_pos == spinor_pkg::PosW'(1)) begin
            // the grant is decided once, on the address byte
            if (wel) begin
              prog_ok   = 1'b1;
              wel       = 1'b0;
              next_addr = 8'(int'(b) % MemBytes);
            end
          end else if (prog_ok) begin
            flash_mem[next_addr] = flash_mem[next_addr] & b;
            next_addr = 8'((int'(next_addr) + 1) % MemBytes);
          end
        end
        default: ;
      endcase
    end
    return reply;
  endfunction

  // predict on every input transaction, check every output transaction
  always @(posedge clk_i) begin : check_replies
    logic [7:0] want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_rx.push_back(flash_reply(start_of_transfer_i, tx_byte_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_rx.size() == 0) begin
          report_error($sformatf("unexpected reply %02h", rx_byte_o));
        end else begin
          want = expected_rx.pop_front();
          if (rx_byte_o !== want) begin
            report_error($sformatf("rx_byte %02h, expected %02h", rx_byte_o, want));
          end
        end
      end
    end
  end

  // receiver stalls: mostly short, now and then long
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else if (out_ready_i) begin
      out_ready_i <= 1'b0;
      ready_hold  <= ($urandom_range(99) < 85) ? $urandom_range(2, 0) : $urandom_range(60, 15);
    end else begin
      out_ready_i <= 1'b1;
      ready_hold  <= $urandom_range(20, 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WatchdogLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // one byte-slot transaction; valid stays high into the next call unless a gap is taken
  task automatic send_byte(input logic sot, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    start_of_transfer_i <= sot;
    tx_byte_i           <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_items++;
  endtask

  function automatic logic [7:0] pick_addr();
    logic [7:0] a;
    // favor the top of the array so transfers overlap and wrap
    if ($urandom_range(99) < 60) a = 8'((248 + $urandom_range(15)) % MemBytes);
    else a = 8'($urandom_range(MemBytes - 1));
    return a;
  endfunction

  task automatic random_transfer();
    int unsigned kind;
    int unsigned len;
    logic [7:0]  op;
    kind = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 0);
    if (kind < 8) begin
      // noise: data bytes that belong to no fresh command
      repeat ($urandom_range(3, 1)) send_byte(1'b0, 8'($urandom_range(255)));
    end else begin
      if (kind < 38) begin
        op = spinor_pkg::OpRead;
      end else if (kind < 63) begin
        op = spinor_pkg::OpProgram;
        if ($urandom_range(4) != 0) send_byte(1'b1, spinor_pkg::OpWren);
      end else if (kind < 67) begin
        op = spinor_pkg::OpErase;
        if ($urandom_range(1) != 0) send_byte(1'b1, spinor_pkg::OpWren);
      end else if (kind < 75) begin
        op = spinor_pkg::OpJedecId;
      end else if (kind < 83) begin
        op = spinor_pkg::OpStatus;
      end else if (kind < 92) begin
        op = spinor_pkg::OpWren;
      end else begin
        op = 8'($urandom_range(255));
      end
      send_byte(1'b1, op);
      for (int i = 0; i < len; i++) begin
        if (i == 0 && (op == spinor_pkg::OpRead || op == spinor_pkg::OpProgram)) begin
          send_byte(1'b0, pick_addr());
        end else begin
          send_byte(1'b0, 8'($urandom_range(255)));
        end
      end
    end
  endtask

  task automatic test_stray_bytes();
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
  endtask

  task automatic test_each_command();
    // id transfer longer than the id
    send_byte(1'b1, spinor_pkg::OpJedecId);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    // program without write enable is ignored
    send_byte(1'b1, spinor_pkg::OpProgram);
    send_byte(1'b0, 8'h10);
    send_byte(1'b0, 8'h00);
    send_byte(1'b1, spinor_pkg::OpWren);
    send_byte(1'b1, spinor_pkg::OpStatus);
    send_byte(1'b0, 8'h00);
    // program across the top of the array
    send_byte(1'b1, spinor_pkg::OpProgram);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h0F);
    send_byte(1'b0, 8'hF0);
    // latch was cleared by program, so erase does nothing
    send_byte(1'b1, spinor_pkg::OpErase);
    send_byte(1'b1, spinor_pkg::OpStatus);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b1, spinor_pkg::OpRead);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    // id transfer cut short
    send_byte(1'b1, spinor_pkg::OpJedecId);
    send_byte(1'b0, 8'h00);
    send_byte(1'b1, spinor_pkg::OpWren);
    send_byte(1'b1, spinor_pkg::OpErase);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'hFF);
  endtask

  task automatic test_random_traffic(input int unsigned until_count);
    while (sent_items < until_count) random_transfer();
  endtask

  task automatic test_back_to_back(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = sent_items + n_items;
    calm = 1'b1;
    while (sent_items < stop_at) random_transfer();
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < MemBytes; i++) flash_mem[i] = spinor_pkg::IdleByte;
    wel       = 1'b0;
    prog_ok   = 1'b0;
    cur_op    = 8'h00;
    next_addr = 8'h00;
    slot_pos  = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_stray_bytes();
    test_each_command();
    test_random_traffic(900);
    test_back_to_back(250);
    test_random_traffic(1330);

    in_valid_i <= 1'b0;
    while (expected_rx.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
